// ----- rtl/core/pva_pkg.sv -----
// pva_pkg: shared constants, types and the arctangent table of the phase vocoder analysis bin
// depends on nothing; used by every module in rtl/core
package pva_pkg;

   localparam int BINS          = 513;
   localparam int STAGES        = 24;
   localparam int BIN_W         = 10;
   localparam int ADDR_W        = 10;
   localparam int ANG_W         = 24;
   localparam int XY_W          = 34;
   localparam int IN_SCALE      = 6;
   localparam int FREQ_W        = 25;
   localparam logic [31:0] GAIN_INV = 32'd2608131496;

   localparam logic [1:0] CSR_FREQ_STEP  = 2'd0;
   localparam logic [1:0] CSR_PHASE_STEP = 2'd1;
   localparam logic [1:0] CSR_HZ_RATE    = 2'd2;

   typedef struct packed {
      logic              vld;
      logic              zero;
      logic signed [XY_W-1:0] x;
      logic signed [XY_W-1:0] y;
      logic [ANG_W-1:0]  z;
      logic [BIN_W-1:0]  idx;
   } cell_type;

   function automatic logic [ANG_W-1:0] atan_entry(input int i);
      logic [ANG_W-1:0] r;
      case (i)
         0: r = 24'd2097152;  1: r = 24'd1238021; 2: r = 24'd654136; 3: r = 24'd332050;
         4: r = 24'd166669;   5: r = 24'd83416;   6: r = 24'd41718;  7: r = 24'd20860;
         8: r = 24'd10430;    9: r = 24'd5215;   10: r = 24'd2608;  11: r = 24'd1304;
         12: r = 24'd652;    13: r = 24'd326;    14: r = 24'd163;   15: r = 24'd81;
         16: r = 24'd41;     17: r = 24'd20;     18: r = 24'd10;    19: r = 24'd5;
         20: r = 24'd3;      21: r = 24'd1;      22: r = 24'd1;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

// ----- rtl/core/phase_vocoder_analysis_bin.sv -----
// phase_vocoder_analysis_bin: top level, cordic cell chain, phase store and frequency path
// depends on pva_pkg and pva_cordic_cell
//
// usage:
//   req_ channel takes one bin item per cycle while req_tready is high: tdata = {bin_index, bin_imag, bin_real}
//   rsp_ channel returns one item per input: tdata = {true_frequency, magnitude}
//   csr_ port writes bin_freq_step (0), bin_phase_step (1), hz_per_hop_rate (2)
// pipeline: a pre-rotation register, 24 cordic cells and 4 back-end stages
// throughput: one item per cycle unless the receiver stalls; the whole chain advances together with the output
//   register, so req_tready = rsp_tready or an empty output register
// the phase store has 513 entries in a memory; a clearing pass over all 513 entries runs
//   after reset and req_tready stays low during it
// read-after-write for the same bin in flight is forwarded from the back-end stages
// when the receiver stalls the whole pipe freezes and nothing is lost
module phase_vocoder_analysis_bin (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // bin_real[23:0], bin_imag[47:24], bin_index[57:48]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // magnitude[23:0], true_frequency[48:24]
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [23:0] csr_wdata
);

   localparam int S = pva_pkg::STAGES;
   localparam int AW = pva_pkg::ANG_W;

   // configuration
   logic [23:0] freq_step_ff, phase_step_ff, hz_rate_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         freq_step_ff  <= 24'd11025;
         phase_step_ff <= 24'd4194304;
         hz_rate_ff    <= 24'd44101;
      end else if (csr_we) begin
         case (csr_index)
            pva_pkg::CSR_FREQ_STEP:  freq_step_ff  <= csr_wdata;
            pva_pkg::CSR_PHASE_STEP: phase_step_ff <= csr_wdata;
            pva_pkg::CSR_HZ_RATE:    hz_rate_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // clearing pass
   logic        clr_ff;
   logic [pva_pkg::ADDR_W-1:0] clr_addr_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff      <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_ff) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
         if (clr_addr_ff == pva_pkg::ADDR_W'(pva_pkg::BINS - 1)) clr_ff <= 1'b0;
      end
   end

   // global advance
   logic en;
   assign en = rsp_tready || !rsp_tvalid;
   assign req_tready = en && !clr_ff;

   // pre-rotation cell: scale and turn left half plane
   pva_pkg::cell_type chain [0:S];
   pva_pkg::cell_type pre_ff;
   logic signed [23:0] re, im;
   logic signed [pva_pkg::XY_W-1:0] xs, ys;
   assign re = req_tdata[23:0];
   assign im = req_tdata[47:24];
   assign xs = pva_pkg::XY_W'(re) <<< pva_pkg::IN_SCALE;
   assign ys = pva_pkg::XY_W'(im) <<< pva_pkg::IN_SCALE;

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_ff.vld <= 1'b0;
      end else if (en) begin
         pre_ff.vld  <= req_tvalid && req_tready;
         pre_ff.zero <= (re == 0) && (im == 0);
         pre_ff.idx  <= req_tdata[57:48];
         if (re < 0) begin
            pre_ff.x <= -xs;
            pre_ff.y <= -ys;
            pre_ff.z <= 24'h800000;
         end else begin
            pre_ff.x <= xs;
            pre_ff.y <= ys;
            pre_ff.z <= '0;
         end
      end
   end
   assign chain[0] = pre_ff;

   for (genvar g = 0; g < S; g++) begin : g_cell
      pva_cordic_cell u_cell (
         .clock(clock), .reset(reset), .en(en), .shift(5'(g)),
         .cell_in(chain[g]), .cell_out(chain[g+1])
      );
   end

   pva_pkg::cell_type c_out;
   assign c_out = chain[S];

   // stage a: magnitude multiply, phase store read, expected advance
   logic        a_vld_ff, a_inr_ff;
   logic [AW-1:0] a_ph_ff, a_exp_ff;
   logic [63:0] a_mag_ff;
   logic [pva_pkg::BIN_W-1:0] a_idx_ff;
   logic [AW-1:0] mem [0:pva_pkg::BINS-1];
   logic [AW-1:0] rd_ff;
   logic [AW-1:0] ph_now;
   logic [31:0]   x_pos;
   logic          in_range;
   assign ph_now   = c_out.zero ? '0 : c_out.z;
   assign x_pos    = (c_out.zero || c_out.x < 0) ? '0 : c_out.x[31:0];
   assign in_range = c_out.idx < pva_pkg::BIN_W'(pva_pkg::BINS);

   // write on stage b; forwarding covers same-bin items one and two apart
   logic        b_vld_ff, b_inr_ff;
   logic [AW-1:0] b_ph_ff, b_exp_ff;
   logic [pva_pkg::BIN_W-1:0] b_idx_ff;
   logic [23:0] b_mag_ff;

   always_ff @(posedge clock) begin
      if (clr_ff) begin
         mem[clr_addr_ff] <= '0;
      end else if (en && a_vld_ff && a_inr_ff) begin
         mem[a_idx_ff[pva_pkg::ADDR_W-1:0]] <= a_ph_ff;
      end
      if (en) rd_ff <= mem[c_out.idx[pva_pkg::ADDR_W-1:0]];
   end

   // forwarding flags captured at stage a for older writes
   logic fwd_a_ff, fwd_b_ff;
   logic [AW-1:0] fwd_b_ph_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else if (en) begin
         a_vld_ff <= c_out.vld;
         a_inr_ff <= in_range;
         a_ph_ff  <= ph_now;
         a_idx_ff <= c_out.idx;
         a_mag_ff <= 64'(x_pos) * 64'(pva_pkg::GAIN_INV);
         a_exp_ff <= AW'(c_out.idx * phase_step_ff);
         fwd_a_ff <= a_vld_ff && a_inr_ff && (a_idx_ff == c_out.idx);
         fwd_b_ff <= b_vld_ff && b_inr_ff && (b_idx_ff == c_out.idx);
         fwd_b_ph_ff <= b_ph_ff;
      end
   end

   // stage b: delta and deviation, magnitude round
   logic [AW-1:0] old_ph;
   logic [63:0]   mag_r;
   assign old_ph = !a_inr_ff ? '0 : fwd_a_ff ? b_ph_ff : fwd_b_ff ? fwd_b_ph_ff : rd_ff;
   assign mag_r  = (a_mag_ff + (64'd1 << 37)) >> 38;

   logic signed [AW-1:0] b_dev_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff <= 1'b0;
      end else if (en) begin
         b_vld_ff <= a_vld_ff;
         b_inr_ff <= a_inr_ff;
         b_ph_ff  <= a_ph_ff;
         b_idx_ff <= a_idx_ff;
         b_exp_ff <= a_exp_ff;
         b_dev_ff <= a_ph_ff - old_ph - a_exp_ff;
         b_mag_ff <= (mag_r > 64'hFFFFFF) ? 24'hFFFFFF : mag_r[23:0];
      end
   end

   // stage c: products
   logic        c_vld_ff;
   logic [23:0] c_mag_ff;
   logic signed [49:0] c_dev_ff;
   logic [33:0] c_base_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         c_vld_ff <= 1'b0;
      end else if (en) begin
         c_vld_ff  <= b_vld_ff;
         c_mag_ff  <= b_mag_ff;
         c_dev_ff  <= 50'(b_dev_ff) * $signed({26'd0, hz_rate_ff});
         c_base_ff <= 34'(b_idx_ff) * 34'(freq_step_ff);
      end
   end

   // stage d: sum and saturate into the output register
   logic signed [51:0] sum;
   assign sum = 52'($signed({18'd0, c_base_ff}))
              + 52'((c_dev_ff + 50'sd8388608) >>> 24);

   logic        o_vld_ff;
   logic [55:0] o_data_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         o_vld_ff <= 1'b0;
      end else if (en) begin
         o_vld_ff <= c_vld_ff;
         o_data_ff[23:0]  <= c_mag_ff;
         o_data_ff[55:49] <= '0;
         if (sum > 52'sd16777215)       o_data_ff[48:24] <= 25'h0FFFFFF;
         else if (sum < -52'sd16777216) o_data_ff[48:24] <= 25'h1000000;
         else                           o_data_ff[48:24] <= sum[24:0];
      end
   end
   assign rsp_tvalid = o_vld_ff;
   assign rsp_tdata  = o_data_ff;

   // checks
   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      clr_ff |-> !req_tready) else $error("item taken during clearing pass");
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> $stable(rsp_tdata) && rsp_tvalid)
      else $error("output changed under stall");
   a_no_accept_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |-> !req_tready) else $error("accept while frozen");

endmodule

// ----- rtl/core/pva_cordic_cell.sv -----
// pva_cordic_cell: one vectoring rotation of the cordic chain, registered
// depends on pva_pkg
module pva_cordic_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic [4:0]         shift,
   input  pva_pkg::cell_type  cell_in,
   output pva_pkg::cell_type  cell_out
);

   pva_pkg::cell_type cell_ff, cell_in_nx;
   logic [pva_pkg::ANG_W-1:0] atan_val;

   // shift is tied to a constant per cell, so the table lookup folds away
   assign atan_val = pva_pkg::atan_entry(int'(shift));

   always_comb begin
      cell_in_nx = cell_in;
      if (cell_in.y < 0) begin
         cell_in_nx.x = cell_in.x - (cell_in.y >>> shift);
         cell_in_nx.y = cell_in.y + (cell_in.x >>> shift);
         cell_in_nx.z = cell_in.z - atan_val;
      end else begin
         cell_in_nx.x = cell_in.x + (cell_in.y >>> shift);
         cell_in_nx.y = cell_in.y - (cell_in.x >>> shift);
         cell_in_nx.z = cell_in.z + atan_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.vld <= 1'b0;
      end else if (en) begin
         cell_ff <= cell_in_nx;
      end
   end

   assign cell_out = cell_ff;

endmodule

// ----- tb/phase_vocoder_analysis_bin_test.sv -----
// phase_vocoder_analysis_bin_test: self-checking bench for the phase vocoder analysis bin
// drives bins on the req_ stream, predicts magnitude and true frequency, checks rsp_ items
// depends on pva_pkg and the phase_vocoder_analysis_bin rtl
`timescale 1ns / 100ps

module phase_vocoder_analysis_bin_test;

   // expected (magnitude, true_frequency) items in arrival order
   class bin_scoreboard;
      logic [55:0] pending[$];

      function void note_bin(logic [55:0] exp_data);
         pending.push_back(exp_data);
      endfunction

      // empty string when the item matches
      function string check_bin(logic [55:0] got);
         logic [55:0] e;
         if (pending.size() == 0) return $sformatf("unexpected item %h", got);
         e = pending.pop_front();
         if (got[48:0] !== e[48:0])
            return $sformatf("magnitude got %0d exp %0d, true_frequency got %h exp %h",
                             got[23:0], e[23:0], got[48:24], e[48:24]);
         return "";
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;   // bin_real[23:0], bin_imag[47:24], bin_index[57:48]
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [55:0] rsp_tdata;        // magnitude[23:0], true_frequency[48:24]
   logic        csr_we = 0;
   logic [1:0]  csr_index = pva_pkg::CSR_FREQ_STEP;
   logic [23:0] csr_wdata = '0;

   bin_scoreboard sb;
   int            fails = 0;
   longint        cycles = 0;
   bit            quiet = 0;      // no idling on either side while set

   // predictor state
   logic [23:0] freq_step, phase_step, hz_rate;
   logic [23:0] phase_mem[pva_pkg::BINS];

   // atan table in 2^24 per turn
   localparam logic [23:0] ATAN[24] = '{
      24'd2097152, 24'd1238021, 24'd654136, 24'd332050, 24'd166669, 24'd83416,
      24'd41718, 24'd20860, 24'd10430, 24'd5215, 24'd2608, 24'd1304, 24'd652,
      24'd326, 24'd163, 24'd81, 24'd41, 24'd20, 24'd10, 24'd5, 24'd3, 24'd1,
      24'd1, 24'd0};

   phase_vocoder_analysis_bin uut (.*);

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > 400000) begin
         $display("tb: failure");
         $finish;
      end
   end

   task automatic report(string what);
      $display("mismatch: %s", what);
      fails++;
   endtask

   // predict one bin and update the phase store copy
   function automatic logic [55:0] predict_bin(logic [63:0] d);
      longint x, y, dx, dy, dev, freq, m;
      logic [23:0] z, old, delta, adv, devu;
      logic [9:0]  idx;
      x = longint'($signed(d[23:0])) * 64;
      y = longint'($signed(d[47:24])) * 64;
      idx = d[57:48];
      z = 0;
      m = 0;
      if (x != 0 || y != 0) begin
         if (x < 0) begin
            x = -x; y = -y; z = 24'h800000;
         end
         for (int i = 0; i < 24; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y < 0) begin
               x -= dx; y += dy; z -= ATAN[i];
            end else begin
               x += dx; y -= dy; z += ATAN[i];
            end
         end
         if (x < 0) x = 0;
         m = (x * longint'(pva_pkg::GAIN_INV) + (longint'(1) << 37)) >>> 38;
         if (m > 24'hFFFFFF) m = 24'hFFFFFF;
      end
      old = 0;
      if (idx < pva_pkg::BINS) begin
         old = phase_mem[idx];
         phase_mem[idx] = z;
      end
      delta = z - old;
      adv = 24'(longint'(idx) * longint'(phase_step));
      devu = delta - adv;
      dev = longint'($signed(devu));
      freq = longint'(idx) * longint'(freq_step)
           + ((dev * longint'(hz_rate) + 64'sh800000) >>> 24);
      if (freq > 16777215) freq = 16777215;
      if (freq < -16777216) freq = -16777216;
      return {7'b0, 25'(freq), 24'(m)};
   endfunction

   task automatic write_reg(logic [1:0] idx, logic [23:0] val);
      csr_we <= 1; csr_index <= idx; csr_wdata <= val;
      @(negedge clock);
      csr_we <= 0;
      case (idx)
         pva_pkg::CSR_FREQ_STEP:  freq_step = val;
         pva_pkg::CSR_PHASE_STEP: phase_step = val;
         default:                 hz_rate = val;
      endcase
      @(negedge clock);
   endtask

   // offer one item, holding it until accepted; tvalid stays up for a following item
   task automatic send_bin(logic [23:0] re, logic [23:0] im, logic [9:0] idx);
      while (!quiet && $urandom_range(99) < 32) begin
         req_tvalid <= 0;
         @(negedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {6'b0, idx, im, re};
      do @(posedge clock); while (!req_tready);
      sb.note_bin(predict_bin({6'b0, idx, im, re}));
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task automatic random_bin(int near);
      logic [23:0] re, im;
      logic [9:0]  idx;
      re = 24'($urandom); im = 24'($urandom);
      if ($urandom_range(3) == 0) re = 24'($urandom_range(3) - 2);
      if ($urandom_range(3) == 0) im = 24'($urandom_range(3) - 2);
      idx = (near && $urandom_range(9) != 0) ? 10'($urandom_range(7)) :
            ($urandom_range(9) == 0 ? 10'($urandom) : 10'($urandom_range(512)));
      send_bin(re, im, idx);
   endtask

   // receiver: random stalls, check on every accepted item
   always @(negedge clock)
      rsp_tready <= quiet || ($urandom_range(99) >= 32);

   always @(posedge clock) begin
      string msg;
      if (!reset && rsp_tvalid && rsp_tready) begin
         msg = sb.check_bin(rsp_tdata);
         if (msg != "") report(msg);
      end
   end

   initial begin
      sb = new();
      freq_step = 11025; phase_step = 4194304; hz_rate = 44101;
      foreach (phase_mem[i]) phase_mem[i] = 0;
      repeat (2) @(negedge clock);
      reset <= 0;

      // directed: extremes, zero vector, axes, out-of-store index, repeat bins
      send_bin(24'h0, 24'h0, 10'd0);
      send_bin(24'h7FFFFF, 24'h0, 10'd1);
      send_bin(24'h800000, 24'h0, 10'd1);
      send_bin(24'h0, 24'h7FFFFF, 10'd2);
      send_bin(24'h0, 24'h800000, 10'd2);
      send_bin(24'h7FFFFF, 24'h7FFFFF, 10'd512);
      send_bin(24'h800000, 24'h800000, 10'd512);
      send_bin(24'h800000, 24'h7FFFFF, 10'd513);
      send_bin(24'h000001, 24'hFFFFFF, 10'd1023);
      send_bin(24'hFFFFFF, 24'h000001, 10'd3);
      send_bin(24'h123456, 24'hABCDEF, 10'd3);
      drain();

      write_reg(pva_pkg::CSR_FREQ_STEP, 24'hFFFFFF);
      write_reg(pva_pkg::CSR_PHASE_STEP, 24'h0);
      write_reg(pva_pkg::CSR_HZ_RATE, 24'hFFFFFF);
      send_bin(24'h400000, 24'hC00000, 10'd1023);
      send_bin(24'h800000, 24'h000001, 10'd0);
      send_bin(24'h000100, 24'hFFFF00, 10'd1);
      drain();
      write_reg(pva_pkg::CSR_FREQ_STEP, 24'h0);
      write_reg(pva_pkg::CSR_PHASE_STEP, 24'hFFFFFF);
      write_reg(pva_pkg::CSR_HZ_RATE, 24'h0);
      send_bin(24'h3FFFFF, 24'h3FFFFF, 10'd700);
      send_bin(24'h7FFFFF, 24'h800000, 10'd5);
      drain();

      // random phases with different settings
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: begin
               write_reg(pva_pkg::CSR_FREQ_STEP, 24'd11025);
               write_reg(pva_pkg::CSR_PHASE_STEP, 24'd4194304);
               write_reg(pva_pkg::CSR_HZ_RATE, 24'd44101);
            end
            5: begin
               write_reg(pva_pkg::CSR_FREQ_STEP, 24'hFFFFFF);
               write_reg(pva_pkg::CSR_PHASE_STEP, 24'hFFFFFF);
               write_reg(pva_pkg::CSR_HZ_RATE, 24'hFFFFFF);
            end
            default: begin
               write_reg(pva_pkg::CSR_FREQ_STEP, 24'($urandom_range(40000)));
               write_reg(pva_pkg::CSR_PHASE_STEP, 24'($urandom));
               write_reg(pva_pkg::CSR_HZ_RATE, 24'($urandom_range(200000)));
            end
         endcase
         quiet = (ph == 2);
         for (int n = 0; n < 150; n++) begin
            random_bin(ph == 3);
            // pause once until the pipe is empty
            if (ph == 1 && n == 75) begin
               req_tvalid <= 0;
               while (sb.pending.size() != 0) @(negedge clock);
            end
         end
         quiet = 0;
         drain();
      end

      if (fails == 0 && sb.pending.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule
